[rtl/irs_pkg.sv]
// ----------------------------------------------------------------------------
// irs_pkg: shared types and constants of the radix symbol converter
// Transaction payloads, the controller to datapath command and status
// groups, and the sizes of the digit datapath.
// ----------------------------------------------------------------------------
package irs_pkg;

   // sizes
   localparam int NumberWidth   = 64;
   localparam int MaxDigits     = 64;
   localparam int MaxBase       = 256;
   localparam int MinBase       = 2;
   localparam int SymbolWidth   = 8;
   localparam int DigitWidth    = 8;
   localparam int BaseWidth     = 9;
   localparam int AlphaDepth    = 256;
   localparam int AlphaAddrW    = 8;
   localparam int DigitAddrW    = $clog2(MaxDigits);
   localparam int BitsPerCycle  = 8;
   localparam int CyclesPerDiv  = NumberWidth / BitsPerCycle;
   localparam int StepWidth     = $clog2(CyclesPerDiv);

   // operation codes
   localparam logic OpLoad    = 1'b0;
   localparam logic OpConvert = 1'b1;

   // base register saturation limits
   localparam logic [BaseWidth-1:0] BaseLow  = BaseWidth'(MinBase);
   localparam logic [BaseWidth-1:0] BaseHigh = BaseWidth'(MaxBase);

   // input transaction
   typedef struct packed {
      logic                   op;
      logic [AlphaAddrW-1:0]  entry_index;
      logic [SymbolWidth-1:0] entry_symbol;
      logic [NumberWidth-1:0] number;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [SymbolWidth-1:0] symbol;
      logic [DigitWidth-1:0]  digit_value;
      logic                   last;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_entry;
      logic load_number;
      logic div_step;
      logic store_digit;
      logic emit_read;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic quot_zero;
      logic buf_full;
      logic rd_last;
      logic pipe_busy;
   } status_type;

endpackage

[rtl/integer_to_radix_symbols_top.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_symbols_top: number to alphabet symbols in base N
// Converts a 64-bit unsigned number to its base-N digits, most significant
// first, each sent as a byte looked up in a loaded alphabet table.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low. With op at
//   load it writes entry_symbol into the alphabet at entry_index in that
//   same cycle and busy stays low. With op at convert the number is divided
//   repeatedly by the base register; each division retires eight quotient
//   bits a cycle, and each digit is then stored in the digit buffer.
//   After the last digit the buffer is read back in reverse, one symbol a
//   cycle on rsp_strobe/rsp_data, the final digit flagged with last; the
//   first symbol passes the digit read and alphabet output registers.
//   A number with D digits (D from 1 to 64, 64 only in base 2) keeps busy
//   high until its read-out is drained. Zero gives one symbol, alphabet
//   entry 0.
//   csr_wr_en/csr_wr_data write the base, saturated to 2..256; write it only
//   while busy is low. Reset sets the base to 2 and empties the pipeline;
//   the alphabet is not cleared and must be loaded before use.
//   Results are shown for one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module integer_to_radix_symbols_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  irs_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output irs_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [irs_pkg::BaseWidth-1:0] csr_wr_data
);

   irs_pkg::cmd_type    cmd;
   irs_pkg::status_type status;

   // sequencer
   irs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // datapath
   irs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

[rtl/irs_ctrl.sv]
// ----------------------------------------------------------------------------
// irs_ctrl: sequencer of the radix symbol converter
// Steps the datapath through division passes, digit stores, the reversed
// read-out of the digit buffer and the drain of the output pipeline.
// ----------------------------------------------------------------------------
module irs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_op,
   input  irs_pkg::status_type status,
   output irs_pkg::cmd_type    cmd,
   output logic                busy
);

   typedef enum logic [4:0] {
      IDLE  = 5'b00001,
      DIV   = 5'b00010,
      STORE = 5'b00100,
      EMIT  = 5'b01000,
      DRAIN = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [irs_pkg::StepWidth-1:0]      step_ff, step_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               if (req_op == irs_pkg::OpConvert) begin
                  cmd.load_number = 1'b1;
                  step_in         = '0;
                  state_in        = DIV;
               end else begin
                  cmd.load_entry = 1'b1;
               end
            end
         end
         DIV: begin
            cmd.div_step = 1'b1;
            step_in      = irs_pkg::StepWidth'(step_ff + 1'b1);
            if (step_ff == irs_pkg::StepWidth'(irs_pkg::CyclesPerDiv - 1)) begin
               state_in = STORE;
            end
         end
         STORE: begin
            cmd.store_digit = 1'b1;
            step_in         = '0;
            if (status.quot_zero || status.buf_full) begin
               state_in = EMIT;
            end else begin
               state_in = DIV;
            end
         end
         EMIT: begin
            cmd.emit_read = 1'b1;
            if (status.rd_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy = (state_ff != IDLE);

endmodule

[rtl/irs_datapath.sv]
// ----------------------------------------------------------------------------
// irs_datapath: division, digit buffer and alphabet lookup
// Holds the base register, a shift-subtract divider retiring eight quotient
// bits a cycle, the digit buffer and the alphabet memory with its pipeline.
// ----------------------------------------------------------------------------
module irs_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  irs_pkg::req_type                    req_data,
   input  irs_pkg::cmd_type                    cmd,
   output irs_pkg::status_type                 status,
   input  logic                                csr_wr_en,
   input  logic [irs_pkg::BaseWidth-1:0]       csr_wr_data,
   output logic                                rsp_strobe,
   output irs_pkg::rsp_type                    rsp_data
);

   logic [irs_pkg::BaseWidth-1:0]   base_ff;
   logic [irs_pkg::NumberWidth-1:0] num_ff, num_in;
   logic [irs_pkg::DigitWidth-1:0]  rem_ff, rem_in;
   logic [irs_pkg::DigitAddrW-1:0]  wr_ptr_ff;
   logic [irs_pkg::DigitAddrW-1:0]  rd_ptr_ff;
   logic [irs_pkg::DigitWidth-1:0]  digit_mem [irs_pkg::MaxDigits];
   logic [irs_pkg::SymbolWidth-1:0] alpha_mem [irs_pkg::AlphaDepth];
   logic [irs_pkg::DigitWidth-1:0]  rd_digit_ff;
   logic                            rd_valid_ff;
   logic                            rd_last_ff;
   logic [irs_pkg::SymbolWidth-1:0] out_symbol_ff;
   logic [irs_pkg::DigitWidth-1:0]  out_digit_ff;
   logic                            out_valid_ff;
   logic                            out_last_ff;

   // base register with saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= irs_pkg::BaseLow;
      end else if (csr_wr_en) begin
         if (csr_wr_data < irs_pkg::BaseLow) begin
            base_ff <= irs_pkg::BaseLow;
         end else if (csr_wr_data > irs_pkg::BaseHigh) begin
            base_ff <= irs_pkg::BaseHigh;
         end else begin
            base_ff <= csr_wr_data;
         end
      end
   end

   // eight restoring division steps, quotient shifts in at the bottom
   always_comb begin
      logic [irs_pkg::BaseWidth-1:0] part;
      num_in = num_ff;
      rem_in = rem_ff;
      for (int i = 0; i < irs_pkg::BitsPerCycle; i++) begin
         part   = {rem_in, num_in[irs_pkg::NumberWidth-1]};
         num_in = {num_in[irs_pkg::NumberWidth-2:0], 1'b0};
         if (part >= base_ff) begin
            rem_in    = irs_pkg::DigitWidth'(part - base_ff);
            num_in[0] = 1'b1;
         end else begin
            rem_in = part[irs_pkg::DigitWidth-1:0];
         end
      end
   end

   // dividend, remainder and buffer pointers
   always_ff @(posedge clock) begin
      if (cmd.load_number) begin
         num_ff    <= req_data.number;
         rem_ff    <= '0;
         wr_ptr_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end else if (cmd.store_digit) begin
         rem_ff    <= '0;
         wr_ptr_ff <= irs_pkg::DigitAddrW'(wr_ptr_ff + 1'b1);
      end
      if (cmd.store_digit) begin
         rd_ptr_ff <= wr_ptr_ff;
      end else if (cmd.emit_read) begin
         rd_ptr_ff <= irs_pkg::DigitAddrW'(rd_ptr_ff - 1'b1);
      end
   end

   // digit buffer, least significant digit at the lowest address
   always_ff @(posedge clock) begin
      if (cmd.store_digit) begin
         digit_mem[wr_ptr_ff] <= rem_ff;
      end
      if (cmd.emit_read) begin
         rd_digit_ff <= digit_mem[rd_ptr_ff];
         rd_last_ff  <= (rd_ptr_ff == '0);
      end
   end

   // alphabet table
   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         alpha_mem[req_data.entry_index] <= req_data.entry_symbol;
      end
      if (rd_valid_ff) begin
         out_symbol_ff <= alpha_mem[rd_digit_ff];
         out_digit_ff  <= rd_digit_ff;
         out_last_ff   <= rd_last_ff;
      end
   end

   // output pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.emit_read;
         out_valid_ff <= rd_valid_ff;
      end
   end

   // status back to the sequencer
   assign status.quot_zero = (num_ff == '0);
   assign status.buf_full  = (wr_ptr_ff == irs_pkg::DigitAddrW'(irs_pkg::MaxDigits - 1));
   assign status.rd_last   = (rd_ptr_ff == '0);
   assign status.pipe_busy = rd_valid_ff;

   // result transaction
   assign rsp_strobe           = out_valid_ff;
   assign rsp_data.symbol      = out_symbol_ff;
   assign rsp_data.digit_value = out_digit_ff;
   assign rsp_data.last        = out_last_ff;

endmodule

[test/tb_integer_to_radix_symbols_top.sv]
// ----------------------------------------------------------------------------
// tb_integer_to_radix_symbols_top: self-checking bench for the radix converter
// Fills the low alphabet entries and the top one, steps the base register
// through small radixes and its saturation limits, and checks every symbol
// transaction against a behavioural digit predictor.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_symbols_top;

   localparam int IdleLimit = 4000;
   // entries 0 to AlphaFill-1 and the top entry are loaded before any conversion
   localparam int AlphaFill = 32;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          start       = 1'b0;
   logic                          busy;
   irs_pkg::req_type              req_data    = '0;
   logic                          rsp_strobe;
   irs_pkg::rsp_type              rsp_data;
   logic                          csr_wr_en   = 1'b0;
   logic [irs_pkg::BaseWidth-1:0] csr_wr_data = '0;

   // mirrored block state and the symbols still owed by the block
   logic [irs_pkg::SymbolWidth-1:0] alphabet_mirror [irs_pkg::AlphaDepth];
   logic [irs_pkg::BaseWidth-1:0]   radix_mirror = irs_pkg::BaseLow;
   irs_pkg::rsp_type                owed_symbols [$];

   int error_count   = 0;
   int convert_count = 0;
   int load_count    = 0;
   int symbol_count  = 0;
   int radix_writes  = 0;
   int idle_cycles   = 0;
   int gap_percent   = 30;

   integer_to_radix_symbols_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always #1 clock = ~clock;

   // base register write with saturation to the legal radix range
   function automatic logic [irs_pkg::BaseWidth-1:0] clamp_radix(
      input logic [irs_pkg::BaseWidth-1:0] value);
      if (value < irs_pkg::BaseLow) begin
         return irs_pkg::BaseLow;
      end
      if (value > irs_pkg::BaseHigh) begin
         return irs_pkg::BaseHigh;
      end
      return value;
   endfunction

   // digits of one number, most significant first, queued as owed symbols
   task automatic predict_symbols(input logic [irs_pkg::NumberWidth-1:0] value);
      logic [irs_pkg::DigitWidth-1:0] digits [irs_pkg::MaxDigits];
      logic [63:0]                    rest;
      logic [63:0]                    radix;
      int                             n_digits;
      irs_pkg::rsp_type               sym;
      rest     = value;
      radix    = 64'(radix_mirror);
      n_digits = 0;
      if (rest == 0) begin
         digits[0] = '0;
         n_digits  = 1;
      end
      while (rest != 0 && n_digits < irs_pkg::MaxDigits) begin
         digits[n_digits] = irs_pkg::DigitWidth'(rest % radix);
         rest             = rest / radix;
         n_digits++;
      end
      for (int k = n_digits - 1; k >= 0; k--) begin
         sym.digit_value = digits[k];
         sym.symbol      = alphabet_mirror[digits[k]];
         sym.last        = (k == 0);
         owed_symbols    = {owed_symbols, sym};
      end
   endtask

   // track accepted transactions and check each symbol as it appears
   always @(posedge clock) begin : symbol_checker
      irs_pkg::rsp_type want;
      if (!reset) begin
         if (csr_wr_en) begin
            radix_mirror = clamp_radix(csr_wr_data);
            radix_writes++;
         end
         if (start && !busy) begin
            if (req_data.op == irs_pkg::OpLoad) begin
               alphabet_mirror[req_data.entry_index] = req_data.entry_symbol;
               load_count++;
            end else begin
               predict_symbols(req_data.number);
               convert_count++;
            end
         end
         if (rsp_strobe) begin
            symbol_count++;
            if (owed_symbols.size() == 0) begin
               $error("unexpected symbol transaction: symbol %0h digit %0h last %0b",
                      rsp_data.symbol, rsp_data.digit_value, rsp_data.last);
               error_count++;
            end else begin
               want = owed_symbols.pop_front();
               if (rsp_data.symbol !== want.symbol) begin
                  $error("symbol: expected %0h, actual %0h", want.symbol, rsp_data.symbol);
                  error_count++;
               end
               if (rsp_data.digit_value !== want.digit_value) begin
                  $error("digit_value: expected %0h, actual %0h",
                         want.digit_value, rsp_data.digit_value);
                  error_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_data.last);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("integer_to_radix_symbols_top: mismatch");
         $finish;
      end
   end

   function automatic irs_pkg::req_type make_load(
      input logic [irs_pkg::AlphaAddrW-1:0]  index,
      input logic [irs_pkg::SymbolWidth-1:0] sym);
      irs_pkg::req_type t;
      t.op           = irs_pkg::OpLoad;
      t.entry_index  = index;
      t.entry_symbol = sym;
      t.number       = {$urandom, $urandom};
      return t;
   endfunction

   function automatic irs_pkg::req_type make_convert(
      input logic [irs_pkg::NumberWidth-1:0] value);
      irs_pkg::req_type t;
      t.op           = irs_pkg::OpConvert;
      t.entry_index  = irs_pkg::AlphaAddrW'($urandom);
      t.entry_symbol = irs_pkg::SymbolWidth'($urandom);
      t.number       = value;
      return t;
   endfunction

   // number shapes: full, shortened, small, near a base power, all ones or zero
   function automatic logic [irs_pkg::NumberWidth-1:0] random_number();
      logic [63:0] full;
      logic [63:0] power;
      full  = {$urandom, $urandom};
      power = 64'd1;
      case ($urandom_range(0, 4))
         0: return full;
         1: return full >> $urandom_range(1, 63);
         2: return 64'($urandom_range(0, 1000));
         3: begin
            repeat ($urandom_range(1, 8)) power = power * 64'(radix_mirror);
            return power - 64'($urandom_range(0, 1));
         end
         default: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      endcase
   endfunction

   function automatic irs_pkg::req_type random_item();
      if ($urandom_range(0, 99) < 20) begin
         return make_load(irs_pkg::AlphaAddrW'($urandom), irs_pkg::SymbolWidth'($urandom));
      end
      return make_convert(random_number());
   endfunction

   // one input transaction, then possibly a burst of idle cycles
   task automatic send_item(input irs_pkg::req_type item);
      int gap;
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if ($urandom_range(0, 99) < gap_percent) begin
         gap = $urandom_range(1, 11);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every owed symbol has come and the block is idle
   task automatic drain_symbols();
      start <= 1'b0;
      do @(posedge clock); while (owed_symbols.size() != 0);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_radix(input logic [irs_pkg::BaseWidth-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_and_write_radix(input logic [irs_pkg::BaseWidth-1:0] value);
      drain_symbols();
      write_radix(value);
   endtask

   // low alphabet entries and the top entry, both symbol extremes included
   task automatic test_alphabet_fill();
      logic [irs_pkg::SymbolWidth-1:0] sym;
      for (int i = 0; i < AlphaFill; i++) begin
         sym = irs_pkg::SymbolWidth'($urandom);
         if (i == 0) begin
            sym = '0;
         end
         send_item(make_load(irs_pkg::AlphaAddrW'(i), sym));
      end
      send_item(make_load(irs_pkg::AlphaAddrW'(irs_pkg::AlphaDepth - 1), '1));
   endtask

   // zero, one, field extremes, base saturation and fresh alphabet entries
   task automatic test_directed();
      send_item(make_convert('0));
      send_item(make_convert(64'd1));
      send_item(make_convert('1));
      send_item(make_convert(64'h8000_0000_0000_0000));
      // low saturation of the base
      drain_and_write_radix(9'd0);
      send_item(make_convert(64'd5));
      drain_and_write_radix(9'd1);
      send_item(make_convert(64'd6));
      // high saturation of the base, digits kept to loaded entries
      drain_and_write_radix(9'd511);
      send_item(make_convert('1));
      send_item(make_convert(64'h1F00_0A01_FF00_1E03));
      drain_and_write_radix(9'd257);
      send_item(make_convert(64'd255));
      send_item(make_convert(64'd256));
      // decimal, with reloaded entries read straight back
      drain_and_write_radix(9'd10);
      send_item(make_convert('1));
      send_item(make_convert(64'd9));
      send_item(make_convert(64'd10));
      send_item(make_load(8'd0, 8'hA5));
      send_item(make_convert('0));
      send_item(make_load(8'd9, 8'h5A));
      send_item(make_convert(64'd99));
      drain_and_write_radix(9'd256);
      send_item(make_convert(64'hFF00_FF00_FF00_FF00));
      drain_and_write_radix(9'd3);
      send_item(make_convert('1));
   endtask

   // random traffic over a spread of bases, each phase started from idle
   task automatic test_random_bases();
      logic [irs_pkg::BaseWidth-1:0] radix_list [10];
      radix_list = '{9'd2, 9'd3, 9'd7, 9'd10, 9'd16, 9'd20, 9'd31, 9'd32, 9'd1, 9'd0};
      radix_list[9] = irs_pkg::BaseWidth'($urandom_range(2, AlphaFill));
      foreach (radix_list[p]) begin
         drain_and_write_radix(radix_list[p]);
         repeat (8) send_item(random_item());
      end
   endtask

   // closing stretch with the sender never idle
   task automatic test_back_to_back();
      drain_and_write_radix(irs_pkg::BaseWidth'($urandom_range(0, AlphaFill)));
      gap_percent = 0;
      repeat (24) send_item(random_item());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_alphabet_fill();
      test_directed();
      test_random_bases();
      test_back_to_back();

      drain_symbols();
      repeat (20) @(posedge clock);
      if (owed_symbols.size() != 0) begin
         $error("%0d symbols never arrived", owed_symbols.size());
         error_count++;
      end
      $display("covered %0d conversions and %0d alphabet loads, %0d symbols checked",
               convert_count, load_count, symbol_count);
      $display("over %0d base register writes including both saturation limits",
               radix_writes);
      if (error_count == 0) begin
         $display("integer_to_radix_symbols_top: match");
      end else begin
         $display("integer_to_radix_symbols_top: mismatch");
      end
      $finish;
   end

endmodule

[integer_to_radix_symbols_top.f]
rtl/irs_pkg.sv
rtl/irs_ctrl.sv
rtl/irs_datapath.sv
rtl/integer_to_radix_symbols_top.sv
test/tb_integer_to_radix_symbols_top.sv
